// ===== rtl/core/sorted_integer_set_unit_macros.svh =====
// Assertion macros shared by the checker of the sorted integer set unit.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef SORTED_INTEGER_SET_UNIT_MACROS_SVH
`define SORTED_INTEGER_SET_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SIS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/sis_pkg.sv =====
// Types, codes and helper functions of the sorted integer set unit.
// No dependencies; used by the sequencer and the top level.
package sis_pkg;

    localparam int VALUE_W   = 64;
    localparam int POS_W     = 8;
    localparam int COUNT_W   = 9;
    localparam int WCODE_W   = 2;

    localparam logic [WCODE_W-1:0] WIDTH_16 = 2'd0;
    localparam logic [WCODE_W-1:0] WIDTH_32 = 2'd1;
    localparam logic [WCODE_W-1:0] WIDTH_64 = 2'd2;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_CHK_CMP,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] count;
        logic [WCODE_W-1:0] width_code;
        logic               full_error;
    } t_result;

    // Narrowest element width that holds v.
    function automatic logic [WCODE_W-1:0] needed_width(input logic [VALUE_W-1:0] v);
        logic [WCODE_W-1:0] w;
        if (v[VALUE_W-1:31] != '0 && v[VALUE_W-1:31] != '1) begin
            w = WIDTH_64;
        end else if (v[VALUE_W-1:15] != '0 && v[VALUE_W-1:15] != '1) begin
            w = WIDTH_32;
        end else begin
            w = WIDTH_16;
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/sorted_integer_set_unit.sv =====
// Top level of the sorted integer set unit: stream ports, output register,
// sequencer and entry store. Depends on sis_pkg, sis_seq and sis_mem.
//
//  channel   direction  handshake              payload
//  s (cmd)   in         i_s_tvalid/o_s_tready  tuser: cmd; tdata: value, position
//  m (res)   out        o_m_tvalid/i_m_tready  tuser: hit, full_error; tdata: rest
//
// One request at a time. A read in range passes the read, wait and done states; a
// read past the end, or a find or remove of a value wider than the width seen so
// far, goes straight to done. A search reads, then compares, once per halving of the
// store, since the read port is registered; an add or remove then moves one entry per
// cycle through the same port. Reset clears state, count, width and output valid.
// A result waits in the output register while the next request is accepted.
module sorted_integer_set_unit #(
    parameter int CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // [63:0] value, [71:64] position
    input  logic [1:0]  i_s_tuser,  // [1:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,  // [63:0] read_value, [72:64] count, [74:73] width_code
    output logic [1:0]  o_m_tuser   // [0] hit, [1] full_error
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                  res_valid, res_ready, req_ready;
    sis_pkg::t_result      res;
    sis_pkg::t_result      r_out;
    logic                  r_out_valid;
    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [63:0]           wdata, rdata;

    assign res_ready = !r_out_valid || i_m_tready;

    sis_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (req_ready),
        .i_cmd       (sis_pkg::t_cmd'(i_s_tuser)),
        .i_value     (i_s_tdata[63:0]),
        .i_position  (i_s_tdata[71:64]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    sis_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_s_tready = req_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out.width_code, r_out.count, r_out.read_value};
    assign o_m_tuser  = {r_out.full_error, r_out.hit};

endmodule

// ===== rtl/core/sis_mem.sv =====
// Entry store of the sorted integer set: one write port, one registered read port.
// No dependencies.
module sis_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sis_seq.sv =====
// Command sequencer of the sorted integer set: binary search with one shared
// comparator, then a one-entry-per-cycle tail shift. Depends on sis_pkg.
module sis_seq #(
    parameter int CAPACITY = 256,
    parameter int AW       = 8,
    parameter int CW       = 9
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    output logic                     o_req_ready,
    input  sis_pkg::t_cmd            i_cmd,
    input  logic [sis_pkg::VALUE_W-1:0] i_value,
    input  logic [sis_pkg::POS_W-1:0]   i_position,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output sis_pkg::t_result         o_res,
    output logic                     o_we,
    output logic [AW-1:0]            o_waddr,
    output logic [63:0]              o_wdata,
    output logic [AW-1:0]            o_raddr,
    input  logic [63:0]              i_rdata
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    sis_pkg::t_state r_state, n_state;
    sis_pkg::t_cmd   r_cmd, n_cmd;
    logic signed [63:0] r_value, n_value;
    logic [sis_pkg::POS_W-1:0] r_pos, n_pos;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi, r_idx, n_idx, r_count, n_count;
    logic [AW-1:0] r_waddr, n_waddr;
    logic          r_pend, n_pend;
    logic [sis_pkg::WCODE_W-1:0] r_width, n_width;
    logic          r_hit, n_hit, r_full, n_full;
    logic [63:0]   r_rd, n_rd;

    logic [CW:0]   mid_w, up_w;
    logic [CW-1:0] mid;
    logic          cmp_lt, cmp_eq;
    logic          decide, found;
    logic [sis_pkg::WCODE_W-1:0] need_in, need_reg;

    // The one shared comparator: stored entry against the request value.
    assign cmp_lt = $signed(i_rdata) < r_value;
    assign cmp_eq = i_rdata == r_value;

    assign mid_w    = ({1'b0, r_lo} + {1'b0, r_hi}) >> 1;
    assign mid      = mid_w[CW-1:0];
    assign up_w     = {1'b0, r_idx} + {{CW{1'b0}}, 1'b1};
    assign need_in  = sis_pkg::needed_width(i_value);
    assign need_reg = sis_pkg::needed_width(r_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sis_pkg::ST_IDLE;
            r_count <= '0;
            r_width <= sis_pkg::WIDTH_16;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_width <= n_width;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_value <= n_value;
        r_pos   <= n_pos;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_idx   <= n_idx;
        r_waddr <= n_waddr;
        r_hit   <= n_hit;
        r_full  <= n_full;
        r_rd    <= n_rd;
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_value = r_value;
        n_pos   = r_pos;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_idx   = r_idx;
        n_count = r_count;
        n_width = r_width;
        n_pend  = r_pend;
        n_waddr = r_waddr;
        n_hit   = r_hit;
        n_full  = r_full;
        n_rd    = r_rd;
        o_raddr = '0;
        o_we    = 1'b0;
        o_waddr = r_waddr;
        o_wdata = i_rdata;
        decide  = 1'b0;
        found   = 1'b0;

        unique case (r_state)
            sis_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_cmd   = i_cmd;
                    n_value = i_value;
                    n_pos   = i_position;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_hit   = 1'b0;
                    n_full  = 1'b0;
                    n_rd    = '0;
                    n_pend  = 1'b0;
                    unique case (i_cmd)
                        sis_pkg::CMD_READ: begin
                            n_state = (32'(i_position) < 32'(r_count)) ?
                                      sis_pkg::ST_READ_RD : sis_pkg::ST_DONE;
                        end
                        sis_pkg::CMD_ADD: n_state = sis_pkg::ST_SRCH_RD;
                        default: begin
                            // A value wider than any stored so far cannot be present.
                            n_state = (need_in > r_width) ?
                                      sis_pkg::ST_DONE : sis_pkg::ST_SRCH_RD;
                        end
                    endcase
                end
            end
            sis_pkg::ST_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    o_raddr = mid[AW-1:0];
                    n_idx   = mid;
                    n_state = sis_pkg::ST_SRCH_CMP;
                end else if (r_lo < r_count) begin
                    o_raddr = r_lo[AW-1:0];
                    n_state = sis_pkg::ST_CHK_CMP;
                end else begin
                    decide = 1'b1;
                end
            end
            sis_pkg::ST_SRCH_CMP: begin
                if (cmp_lt) begin
                    n_lo = up_w[CW-1:0];
                end else begin
                    n_hi = r_idx;
                end
                n_state = sis_pkg::ST_SRCH_RD;
            end
            sis_pkg::ST_CHK_CMP: begin
                decide = 1'b1;
                found  = cmp_eq;
            end
            sis_pkg::ST_SHIFT_UP: begin
                // Move entry idx-1 to idx while the previous move is written.
                o_we = r_pend;
                if (r_idx > r_lo) begin
                    o_raddr = AW'(r_idx - 1'b1);
                    n_waddr = r_idx[AW-1:0];
                    n_idx   = r_idx - 1'b1;
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        o_we    = 1'b1;
                        o_waddr = r_lo[AW-1:0];
                        o_wdata = r_value;
                        n_count = r_count + 1'b1;
                        if (need_reg > r_width) begin
                            n_width = need_reg;
                        end
                        n_hit   = 1'b1;
                        n_state = sis_pkg::ST_DONE;
                    end
                end
            end
            sis_pkg::ST_SHIFT_DN: begin
                o_we = r_pend;
                if (up_w < {1'b0, r_count}) begin
                    o_raddr = up_w[AW-1:0];
                    n_waddr = r_idx[AW-1:0];
                    n_idx   = up_w[CW-1:0];
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - 1'b1;
                        n_state = sis_pkg::ST_DONE;
                    end
                end
            end
            sis_pkg::ST_READ_RD: begin
                o_raddr = AW'(r_pos);
                n_state = sis_pkg::ST_READ_WAIT;
            end
            sis_pkg::ST_READ_WAIT: begin
                n_rd    = i_rdata;
                n_hit   = 1'b1;
                n_state = sis_pkg::ST_DONE;
            end
            sis_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = sis_pkg::ST_IDLE;
                end
            end
            default: n_state = sis_pkg::ST_IDLE;
        endcase

        // Search finished: r_lo is the first position whose entry is not below the value.
        if (decide) begin
            n_state = sis_pkg::ST_DONE;
            unique case (r_cmd)
                sis_pkg::CMD_ADD: begin
                    if (!found) begin
                        if (r_count >= CAP_C) begin
                            n_full = 1'b1;
                        end else begin
                            n_idx   = r_count;
                            n_state = sis_pkg::ST_SHIFT_UP;
                        end
                    end
                end
                sis_pkg::CMD_REMOVE: begin
                    if (found) begin
                        n_hit   = 1'b1;
                        n_idx   = r_lo;
                        n_state = sis_pkg::ST_SHIFT_DN;
                    end
                end
                default: n_hit = found;
            endcase
        end
    end

    assign o_req_ready = (r_state == sis_pkg::ST_IDLE);
    assign o_res_valid = (r_state == sis_pkg::ST_DONE);

    always_comb begin
        o_res.hit        = r_hit;
        o_res.read_value = r_rd;
        o_res.count      = sis_pkg::COUNT_W'(r_count);
        o_res.width_code = r_width;
        o_res.full_error = r_full;
    end

endmodule

// ===== rtl/core/sis_checker.sv =====
// Port-level checks of the sorted integer set unit, bound to its top level.
// Depends on sorted_integer_set_unit_macros.svh.
`include "sorted_integer_set_unit_macros.svh"

module sis_checker #(
    parameter int CAPACITY = 256
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [79:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    localparam logic [8:0] CAP_OUT = 9'(CAPACITY);

    logic        out_stall, in_take, full_shown, full_ok, data_shown, read_ok;
    logic [81:0] out_word;

    assign out_stall  = o_m_tvalid && !i_m_tready;
    assign out_word   = {o_m_tuser, o_m_tdata};
    assign in_take    = i_s_tvalid && o_s_tready;
    assign full_shown = o_m_tvalid && o_m_tuser[1];
    assign full_ok    = !o_m_tuser[0] && (o_m_tdata[72:64] == CAP_OUT);
    assign data_shown = o_m_tvalid && (o_m_tdata[63:0] != 64'd0);
    assign read_ok    = o_m_tuser[0] && !o_m_tuser[1];

    // A result that is not taken stays put.
    `SIS_ASSERT_NEXT(a_out_hold, out_stall, o_m_tvalid && $stable(out_word), "stalled result moved")

    // Every request leaves the idle state, so ready drops after a request.
    `SIS_ASSERT_NEXT(a_one_request, in_take, !o_s_tready, "request accepted while busy")

    // A refused add means a full store and no success.
    `SIS_ASSERT_NOW(a_full_count, full_shown, full_ok, "full error on a store that is not full")

    // Read data shows only on a successful read.
    `SIS_ASSERT_NOW(a_read_hit, data_shown, read_ok, "read data without a hit")

endmodule

bind sorted_integer_set_unit sis_checker #(.CAPACITY(CAPACITY)) u_sis_checker (.*);

// ===== verif/tb_sorted_integer_set_unit.sv =====
// Testbench for the sorted integer set unit: a shadow copy of the set predicts
// each result, and stream drivers apply directed, random and fill-to-full traffic.
// Depends on sis_pkg and sorted_integer_set_unit.
module tb_sorted_integer_set_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CAPACITY   = 256;
    localparam int     STALL_MAX  = 5000;
    localparam int     DRAIN_WAIT = 300;
    localparam longint I16_MIN    = 64'shFFFF_FFFF_FFFF_8000;
    localparam longint I16_MAX    = 64'sh0000_0000_0000_7FFF;
    localparam longint I32_MIN    = 64'shFFFF_FFFF_8000_0000;
    localparam longint I32_MAX    = 64'sh0000_0000_7FFF_FFFF;
    localparam longint I64_MIN    = 64'sh8000_0000_0000_0000;
    localparam longint I64_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;

    // Shadow of the set: applies each accepted request and queues the result it must give.
    class sorted_set_shadow;
        longint           store [CAPACITY];
        int unsigned      n_entries;
        logic [1:0]       wlevel;
        sis_pkg::t_result pending_results [$];
        int unsigned      fails;

        function new();
            n_entries = 0;
            wlevel    = sis_pkg::WIDTH_16;
            fails     = 0;
        endfunction

        function logic [1:0] width_of(longint v);
            if (v < I32_MIN || v > I32_MAX) return sis_pkg::WIDTH_64;
            if (v < I16_MIN || v > I16_MAX) return sis_pkg::WIDTH_32;
            return sis_pkg::WIDTH_16;
        endfunction

        // First slot whose entry is not below v; true when that entry equals v.
        function bit locate_slot(longint v, output int unsigned slot);
            int unsigned lo, hi, mid;
            lo = 0;
            hi = n_entries;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (store[mid] < v) lo = mid + 1;
                else hi = mid;
            end
            slot = lo;
            return (lo < n_entries) && (store[lo] == v);
        endfunction

        function bit holds(longint v);
            int unsigned slot;
            return locate_slot(v, slot);
        endfunction

        function longint pick_entry();
            return store[$urandom_range(0, n_entries - 1)];
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        task report(string what);
            if (fails < 40) $display("mismatch: %s", what);
            fails++;
        endtask

        function void accept_request(sis_pkg::t_cmd cmd, longint v, logic [7:0] pos);
            sis_pkg::t_result r;
            int unsigned      slot, i;
            bit               found;
            logic [1:0]       need;
            r    = '0;
            need = width_of(v);
            case (cmd)
                sis_pkg::CMD_ADD: begin
                    found = locate_slot(v, slot);
                    if (!found) begin
                        if (n_entries >= CAPACITY) begin
                            r.full_error = 1'b1;
                        end else begin
                            for (i = n_entries; i > slot; i--) store[i] = store[i - 1];
                            store[slot] = v;
                            n_entries++;
                            if (need > wlevel) wlevel = need;
                            r.hit = 1'b1;
                        end
                    end
                end
                sis_pkg::CMD_REMOVE: begin
                    // A value wider than anything ever stored misses without a search.
                    if (need <= wlevel && locate_slot(v, slot)) begin
                        for (i = slot; i + 1 < n_entries; i++) store[i] = store[i + 1];
                        n_entries--;
                        r.hit = 1'b1;
                    end
                end
                sis_pkg::CMD_FIND: begin
                    if (need <= wlevel && locate_slot(v, slot)) r.hit = 1'b1;
                end
                default: begin
                    if (pos < n_entries) begin
                        r.read_value = store[pos];
                        r.hit        = 1'b1;
                    end
                end
            endcase
            r.count      = sis_pkg::COUNT_W'(n_entries);
            r.width_code = wlevel;
            pending_results.push_back(r);
        endfunction

        task check_result(logic [79:0] data, logic [1:0] user);
            sis_pkg::t_result e;
            if (pending_results.size() == 0) begin
                report("result arrived with no request outstanding");
                return;
            end
            e = pending_results.pop_front();
            if (user[0] !== e.hit)
                report($sformatf("hit %b, expected %b", user[0], e.hit));
            if (data[63:0] !== e.read_value)
                report($sformatf("read_value %h, expected %h", data[63:0], e.read_value));
            if (data[72:64] !== e.count)
                report($sformatf("count %0d, expected %0d", data[72:64], e.count));
            if (data[74:73] !== e.width_code)
                report($sformatf("width_code %0d, expected %0d", data[74:73], e.width_code));
            if (user[1] !== e.full_error)
                report($sformatf("full_error %b, expected %b", user[1], e.full_error));
        endtask
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata  = '0;  // [63:0] value, [71:64] position
    logic [1:0]  i_s_tuser  = '0;  // [1:0] cmd
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [79:0] o_m_tdata;        // [63:0] read_value, [72:64] count, [74:73] width_code
    logic [1:0]  o_m_tuser;        // [0] hit, [1] full_error

    int unsigned      s_idle_pct = 11;
    int unsigned      r_idle_pct = 56;
    int unsigned      quiet_cycles = 0;
    sorted_set_shadow sb = new();

    sorted_integer_set_unit #(.CAPACITY(CAPACITY)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Result side: check what was accepted at this edge, then pick the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
        i_m_tready <= ($urandom_range(0, 99) >= r_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_MAX) begin
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_request(input sis_pkg::t_cmd cmd, input longint v,
                                input logic [7:0] pos);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < s_idle_pct) gap++;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pos, v};
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.accept_request(cmd, v, pos);
    endtask

    function automatic longint random_value();
        longint edges [12] = '{I64_MIN, I64_MAX, I32_MIN, I32_MAX, I16_MIN, I16_MAX,
                               I32_MIN - 1, I32_MAX + 1, I16_MIN - 1, I16_MAX + 1, 0, -1};
        case ($urandom_range(0, 9))
            0, 1, 2: return longint'($urandom_range(0, 40)) - 20;
            3:       return longint'($signed(16'($urandom)));
            4:       return longint'($signed(32'($urandom)));
            5, 6:    return {$urandom, $urandom};
            7:       return edges[$urandom_range(0, 11)];
            default: return (sb.n_entries > 0) ? sb.pick_entry() : {$urandom, $urandom};
        endcase
    endfunction

    function automatic longint fresh_value();
        longint v;
        do v = random_value(); while (sb.holds(v));
        return v;
    endfunction

    task automatic random_request();
        int unsigned   roll;
        sis_pkg::t_cmd c;
        longint        v;
        logic [7:0]    p;
        roll = $urandom_range(0, 99);
        c = (roll < 35) ? sis_pkg::CMD_ADD :
            (roll < 60) ? sis_pkg::CMD_REMOVE :
            (roll < 80) ? sis_pkg::CMD_FIND : sis_pkg::CMD_READ;
        v = random_value();
        p = 8'($urandom);
        if (c == sis_pkg::CMD_READ && sb.n_entries > 0 && $urandom_range(0, 1))
            p = 8'($urandom_range(0, sb.n_entries - 1));
        send_request(c, v, p);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, width boundaries, duplicates, the ends of the set.
        send_request(sis_pkg::CMD_READ,   0, 8'd0);
        send_request(sis_pkg::CMD_REMOVE, 5, 8'd0);
        send_request(sis_pkg::CMD_FIND,   40000, 8'd0);
        send_request(sis_pkg::CMD_FIND,   -1, 8'd0);
        send_request(sis_pkg::CMD_ADD,    I16_MAX, 8'd0);
        send_request(sis_pkg::CMD_ADD,    I16_MIN, 8'd0);
        send_request(sis_pkg::CMD_ADD,    I16_MAX, 8'd0);
        send_request(sis_pkg::CMD_FIND,   I16_MAX + 1, 8'd0);
        send_request(sis_pkg::CMD_ADD,    I16_MAX + 1, 8'd0);
        send_request(sis_pkg::CMD_ADD,    I32_MIN, 8'd0);
        send_request(sis_pkg::CMD_FIND,   I32_MAX + 1, 8'd0);
        send_request(sis_pkg::CMD_REMOVE, I32_MIN - 1, 8'd0);
        send_request(sis_pkg::CMD_ADD,    I64_MIN, 8'd0);
        send_request(sis_pkg::CMD_ADD,    I64_MAX, 8'd0);
        send_request(sis_pkg::CMD_ADD,    0, 8'd0);
        send_request(sis_pkg::CMD_READ,   -1, 8'd0);
        send_request(sis_pkg::CMD_READ,   0, 8'd255);
        send_request(sis_pkg::CMD_READ,   0, 8'(sb.n_entries - 1));
        send_request(sis_pkg::CMD_FIND,   I64_MAX, 8'd0);
        send_request(sis_pkg::CMD_REMOVE, 0, 8'd0);
        send_request(sis_pkg::CMD_REMOVE, 0, 8'd0);
        send_request(sis_pkg::CMD_FIND,   I32_MAX, 8'd0);
        send_request(sis_pkg::CMD_REMOVE, I64_MIN, 8'd0);

        repeat (100) random_request();

        s_idle_pct = 56;
        r_idle_pct = 11;
        // Fill the store, then try adds while full: fresh values are refused,
        // duplicates are not flagged. Then thin it out again.
        while (sb.n_entries < CAPACITY)
            send_request(sis_pkg::CMD_ADD, fresh_value(), 8'($urandom));
        send_request(sis_pkg::CMD_READ, {$urandom, $urandom}, 8'd255);
        repeat (8) begin
            if ($urandom_range(0, 1))
                send_request(sis_pkg::CMD_ADD, fresh_value(), 8'($urandom));
            else
                send_request(sis_pkg::CMD_ADD, sb.pick_entry(), 8'($urandom));
        end
        repeat (60) begin
            if ($urandom_range(0, 3) != 0)
                send_request(sis_pkg::CMD_REMOVE, sb.pick_entry(), 8'($urandom));
            else
                random_request();
        end

        s_idle_pct = 0;
        r_idle_pct = 0;
        repeat (100) random_request();

        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
